/* hw/rtl/gwns_pkg.sv */
// shared cell, status, direction and function codes for the grid wavefront step block
package gwns_pkg;

    localparam logic [2:0] CODE_WALL      = 3'd0;
    localparam logic [2:0] CODE_FREE      = 3'd1;
    localparam logic [2:0] CODE_CHEST     = 3'd2;
    localparam logic [2:0] CODE_TARGET    = 3'd3;
    localparam logic [2:0] CODE_OBJECTIVE = 3'd4;
    localparam logic [2:0] CODE_MOVER     = 3'd5;

    localparam logic [1:0] ST_MOVED    = 2'd0;
    localparam logic [1:0] ST_ADJACENT = 2'd1;
    localparam logic [1:0] ST_NO_PATH  = 2'd2;
    localparam logic [1:0] ST_NO_MOVER = 2'd3;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RUN   = 1'b1;

endpackage

/* hw/rtl/gwns_ram.sv */
// generic single write port ram with registered read
module gwns_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* hw/rtl/grid_wavefront_next_step.sv */
// Grid wavefront path step: one stream in carries map writes and run commands,
// one stream out carries one result per run.
// Input transaction: tuser = func (0 write cell, 1 run step); tdata = row, col,
// cell_code. A write gives no result; writes outside the grid are dropped. A
// run clears the label memory and finds the mover in one scan, checks the mover
// against the target, then makes one scan pass per wavefront level, in which
// each cell of the current level is checked against the target and expanded
// before the scan resumes; then it takes traceback steps back toward the mover
// and moves the mover in S_MOVE_A and S_MOVE_B. The distance and cell memories
// have one read port each and share their read address. Result: tuser = status,
// tdata = mover and next.
// The input stays not ready while a run is in progress; writes are taken
// whenever the block is idle, even while a result waits in the output register.
// A finished run waits until the output register is free. Reset clears the
// control state only; the map is undefined until written.
module grid_wavefront_next_step #(
    parameter int GRID_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row[4:0], col[9:5], cell_code[12:10], zero fill
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mover_row, mover_col, next_row, next_col, zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import gwns_pkg::*;

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = AW + 1;
    localparam logic [DW-1:0] NO_LABEL = '1;
    localparam logic [AW-1:0] GA = AW'(GRID_SIZE);
    localparam logic [CW-1:0] CMAX = CW'(GRID_SIZE - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_TGT_ISS = 4'd2;
    localparam logic [3:0] S_TGT_CHK = 4'd3;
    localparam logic [3:0] S_PASS    = 4'd4;
    localparam logic [3:0] S_EXP_ISS = 4'd5;
    localparam logic [3:0] S_EXP_CHK = 4'd6;
    localparam logic [3:0] S_TR_ISS  = 4'd7;
    localparam logic [3:0] S_TR_CHK  = 4'd8;
    localparam logic [3:0] S_MOVE_A  = 4'd9;
    localparam logic [3:0] S_MOVE_B  = 4'd10;
    localparam logic [3:0] S_RESULT  = 4'd11;

    function automatic logic [AW-1:0] idx_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        idx_of = AW'(r) * GA + AW'(c);
    endfunction

    logic [3:0]    r_state;
    logic [CW-1:0] r_srow, r_scol, r_prow, r_pcol;
    logic          r_iss_done, r_pv;
    logic [CW-1:0] r_cur_r, r_cur_c, r_mv_r, r_mv_c, r_cand_r, r_cand_c;
    logic          r_have_mover, r_phase, r_progress, r_beside, r_cand_v;
    logic [1:0]    r_dir;
    logic [DW-1:0] r_level, r_here;
    logic [1:0]    r_st;
    logic          r_out_valid;
    logic [1:0]    r_out_st;
    logic [19:0]   r_out_data;

    logic [4:0] in_row, in_col;
    logic [2:0] in_code;
    logic       in_fire;

    logic [CW-1:0] nb_r, nb_c;
    logic          nb_ok;
    logic [AW-1:0] nb_idx, scan_idx, rd_addr;
    logic [2:0]    cell_rd;
    logic [DW-1:0] dist_rd;
    logic          cell_we, dist_we;
    logic [AW-1:0] cell_waddr, dist_waddr;
    logic [2:0]    cell_wdata;
    logic [DW-1:0] dist_wdata;
    logic          scan_last, tgt_fin, tgt_found, out_free;

    assign in_row  = s_axis_tdata[4:0];
    assign in_col  = s_axis_tdata[9:5];
    assign in_code = s_axis_tdata[12:10];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {4'd0, r_out_data};

    // neighbour of the current cell in the current direction
    always_comb begin
        nb_r  = r_cur_r;
        nb_c  = r_cur_c;
        nb_ok = 1'b0;
        unique case (r_dir)
            DIR_LEFT: begin
                nb_c  = r_cur_c - CW'(1);
                nb_ok = (r_cur_c != '0);
            end
            DIR_RIGHT: begin
                nb_c  = r_cur_c + CW'(1);
                nb_ok = (r_cur_c != CMAX);
            end
            DIR_UP: begin
                nb_r  = r_cur_r - CW'(1);
                nb_ok = (r_cur_r != '0);
            end
            DIR_DOWN: begin
                nb_r  = r_cur_r + CW'(1);
                nb_ok = (r_cur_r != CMAX);
            end
        endcase
    end

    assign nb_idx    = idx_of(nb_r, nb_c);
    assign scan_idx  = idx_of(r_srow, r_scol);
    assign scan_last = (r_srow == CMAX) && (r_scol == CMAX);
    assign rd_addr   = (r_state == S_INIT || r_state == S_PASS) ? scan_idx : nb_idx;

    always_comb begin
        tgt_found = (r_state == S_TGT_CHK) && (cell_rd == CODE_TARGET);
        tgt_fin   = tgt_found || (r_dir == DIR_DOWN &&
                    (r_state == S_TGT_CHK || !nb_ok));
    end

    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = idx_of(r_cur_r, r_cur_c);
        cell_wdata = CODE_MOVER;
        dist_we    = 1'b0;
        dist_waddr = nb_idx;
        dist_wdata = r_level + DW'(1);
        unique case (r_state)
            S_IDLE: begin
                cell_we    = in_fire && (s_axis_tuser[0] == FUNC_WRITE) &&
                             (32'(in_row) < GRID_SIZE) && (32'(in_col) < GRID_SIZE);
                cell_waddr = AW'(in_row) * GA + AW'(in_col);
                cell_wdata = in_code;
            end
            S_INIT: begin
                dist_we    = !r_iss_done;
                dist_waddr = scan_idx;
                dist_wdata = NO_LABEL;
            end
            S_TGT_ISS, S_TGT_CHK: begin
                dist_we    = tgt_fin && !tgt_found && !r_phase;
                dist_waddr = idx_of(r_mv_r, r_mv_c);
                dist_wdata = '0;
            end
            S_EXP_CHK: begin
                dist_we = (cell_rd == CODE_FREE) && (dist_rd == NO_LABEL);
            end
            S_MOVE_A: cell_we = 1'b1;
            S_MOVE_B: begin
                cell_we    = 1'b1;
                cell_waddr = idx_of(r_mv_r, r_mv_c);
                cell_wdata = CODE_FREE;
            end
            default: ;
        endcase
    end

    gwns_ram #(.W(3), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cell_rd)
    );

    gwns_ram #(.W(DW), .DEPTH(CELLS)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dist_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_iss_done  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && s_axis_tuser[0] == FUNC_RUN) begin
                        r_srow       <= '0;
                        r_scol       <= '0;
                        r_iss_done   <= 1'b0;
                        r_pv         <= 1'b0;
                        r_have_mover <= 1'b0;
                        r_mv_r       <= '0;
                        r_mv_c       <= '0;
                        r_state      <= S_INIT;
                    end
                end
                S_INIT, S_PASS: begin
                    if (r_pv && r_state == S_INIT && cell_rd == CODE_MOVER) begin
                        r_mv_r       <= r_prow;
                        r_mv_c       <= r_pcol;
                        r_have_mover <= 1'b1;
                    end
                    if (r_pv && r_state == S_PASS && dist_rd == r_level) begin
                        // labelled cell of this level: check for target, then expand
                        r_pv    <= 1'b0;
                        r_cur_r <= r_prow;
                        r_cur_c <= r_pcol;
                        r_dir   <= DIR_LEFT;
                        r_phase <= 1'b1;
                        r_state <= S_TGT_ISS;
                    end else if (r_iss_done && !r_pv) begin
                        if (r_state == S_INIT) begin
                            r_cur_r <= r_mv_r;
                            r_cur_c <= r_mv_c;
                            r_dir   <= DIR_LEFT;
                            r_phase <= 1'b0;
                            if (r_have_mover) begin
                                r_state <= S_TGT_ISS;
                            end else begin
                                r_st    <= ST_NO_MOVER;
                                r_state <= S_RESULT;
                            end
                        end else if (r_progress) begin
                            r_level    <= r_level + DW'(1);
                            r_progress <= 1'b0;
                            r_srow     <= '0;
                            r_scol     <= '0;
                            r_iss_done <= 1'b0;
                        end else begin
                            r_st    <= ST_NO_PATH;
                            r_state <= S_RESULT;
                        end
                    end else begin
                        r_pv <= !r_iss_done;
                        if (!r_iss_done) begin
                            r_prow <= r_srow;
                            r_pcol <= r_scol;
                            if (scan_last) begin
                                r_iss_done <= 1'b1;
                            end else if (r_scol == CMAX) begin
                                r_scol <= '0;
                                r_srow <= r_srow + CW'(1);
                            end else begin
                                r_scol <= r_scol + CW'(1);
                            end
                        end
                    end
                end
                S_TGT_ISS, S_TGT_CHK: begin
                    if (tgt_fin) begin
                        r_dir <= DIR_LEFT;
                        if (!r_phase) begin
                            if (tgt_found) begin
                                r_st    <= ST_ADJACENT;
                                r_state <= S_RESULT;
                            end else begin
                                r_level    <= '0;
                                r_progress <= 1'b0;
                                r_srow     <= '0;
                                r_scol     <= '0;
                                r_iss_done <= 1'b0;
                                r_pv       <= 1'b0;
                                r_state    <= S_PASS;
                            end
                        end else if (tgt_found) begin
                            r_here   <= r_level;
                            r_beside <= 1'b0;
                            r_cand_v <= 1'b0;
                            r_state  <= S_TR_ISS;
                        end else begin
                            r_state <= S_EXP_ISS;
                        end
                    end else if (r_state == S_TGT_ISS && nb_ok) begin
                        r_state <= S_TGT_CHK;
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_TGT_ISS;
                    end
                end
                S_EXP_ISS, S_EXP_CHK: begin
                    if (dist_we) begin
                        r_progress <= 1'b1;
                    end
                    if (r_state == S_EXP_ISS && nb_ok) begin
                        r_state <= S_EXP_CHK;
                    end else if (r_dir == DIR_DOWN) begin
                        r_state <= S_PASS;
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_EXP_ISS;
                    end
                end
                S_TR_ISS, S_TR_CHK: begin
                    if (r_state == S_TR_ISS && nb_ok) begin
                        r_state <= S_TR_CHK;
                    end else begin
                        logic beside_n, cand_n;
                        logic [CW-1:0] cr, cc;
                        beside_n = r_beside || (r_state == S_TR_CHK && dist_rd == '0);
                        cand_n   = r_cand_v;
                        cr       = r_cand_r;
                        cc       = r_cand_c;
                        if (!r_cand_v && r_state == S_TR_CHK && dist_rd == r_here - DW'(1)) begin
                            cand_n = 1'b1;
                            cr     = nb_r;
                            cc     = nb_c;
                        end
                        r_beside <= beside_n;
                        r_cand_v <= cand_n;
                        r_cand_r <= cr;
                        r_cand_c <= cc;
                        if (r_dir != DIR_DOWN) begin
                            r_dir   <= r_dir + 2'd1;
                            r_state <= S_TR_ISS;
                        end else if (beside_n || r_here == '0 || r_here == NO_LABEL ||
                                     !cand_n) begin
                            r_state <= S_MOVE_A;
                        end else begin
                            // step one level back toward the mover
                            r_cur_r  <= cr;
                            r_cur_c  <= cc;
                            r_here   <= r_here - DW'(1);
                            r_beside <= 1'b0;
                            r_cand_v <= 1'b0;
                            r_dir    <= DIR_LEFT;
                            r_state  <= S_TR_ISS;
                        end
                    end
                end
                S_MOVE_A: r_state <= S_MOVE_B;
                S_MOVE_B: begin
                    r_st    <= ST_MOVED;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_st;
                        if (r_st == ST_MOVED) begin
                            r_out_data <= {5'(r_cur_c), 5'(r_cur_r), 5'(r_mv_c), 5'(r_mv_r)};
                        end else begin
                            r_out_data <= {10'd0, 5'(r_mv_c), 5'(r_mv_r)};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* test/tb_grid_wavefront_next_step.sv */
// testbench for the grid wavefront path step block: map writes, path runs, result checks
`timescale 1ns / 100ps

module tb_grid_wavefront_next_step;
    import gwns_pkg::*;

    localparam int GRID = 32;
    localparam int CELLS = GRID * GRID;
    localparam int UNLABELED = -1;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [2:0] CODE_SIX = 3'd6;    // unnamed codes, act as walls
    localparam logic [2:0] CODE_SEVEN = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] mover_row;
        logic [4:0] mover_col;
        logic [4:0] next_row;
        logic [4:0] next_col;
    } step_result_t;

    typedef struct packed {
        logic         func;
        logic [4:0]   row;
        logic [4:0]   col;
        logic [2:0]   code;
        logic         fixed;    // use the typed-in result instead of the prediction
        step_result_t want;
    } grid_cmd_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // row[4:0], col[9:5], cell_code[12:10], zero fill
    logic [0:0]  s_axis_tuser;   // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // mover_row, mover_col, next_row, next_col, zero fill
    logic [1:0]  m_axis_tuser;   // status[1:0]

    grid_wavefront_next_step #(.GRID_SIZE(GRID)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    logic [2:0]   shadow_map [CELLS];
    int           wave_dist [CELLS];
    step_result_t pending_steps [$];
    int           n_accepted;
    int           n_runs;
    int           n_mismatch;
    int           cycle_count = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           quiet;
    grid_cmd_t    directed_tbl [25];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic grid_cmd_t wr(int r, int c, logic [2:0] code);
        grid_cmd_t g;
        g = '0;
        g.func = FUNC_WRITE;
        g.row = r[4:0];
        g.col = c[4:0];
        g.code = code;
        return g;
    endfunction

    function automatic grid_cmd_t rn();
        grid_cmd_t g;
        g = '0;
        g.func = FUNC_RUN;
        g.row = 5'($urandom);
        g.col = 5'($urandom);
        g.code = 3'($urandom);
        return g;
    endfunction

    function automatic grid_cmd_t rn_fixed(logic [1:0] st, int mr, int mc);
        grid_cmd_t g;
        g = rn();
        g.fixed = 1'b1;
        g.want = '{st, mr[4:0], mc[4:0], 5'd0, 5'd0};
        return g;
    endfunction

    function automatic bit step_to(int r, int c, int d, output int nr, output int nc);
        nr = r;
        nc = c;
        if (d == DIR_LEFT) nc = c - 1;
        else if (d == DIR_RIGHT) nc = c + 1;
        else if (d == DIR_UP) nr = r - 1;
        else nr = r + 1;
        return nr >= 0 && nc >= 0 && nr < GRID && nc < GRID;
    endfunction

    function automatic bit touches_target(int r, int c);
        int nr, nc;
        for (int d = 0; d < 4; d++)
            if (step_to(r, c, d, nr, nc) && shadow_map[nr * GRID + nc] == CODE_TARGET)
                return 1'b1;
        return 1'b0;
    endfunction

    // breadth-first wavefront from the mover, then walk back to the first step
    task automatic route_one_step(output step_result_t res);
        int  mr, mc, gr, gc, nr, nc, j, lvl, here;
        bit  found_mover, found_goal, grew, near_mover, moved;
        mr = 0; mc = 0; gr = 0; gc = 0;
        found_mover = 0;
        found_goal = 0;
        for (int i = 0; i < CELLS; i++) begin
            wave_dist[i] = UNLABELED;
            if (shadow_map[i] == CODE_MOVER) begin
                mr = i / GRID;
                mc = i % GRID;
                found_mover = 1;
            end
        end
        if (!found_mover) begin
            res = '{ST_NO_MOVER, 5'd0, 5'd0, 5'd0, 5'd0};
            return;
        end
        if (touches_target(mr, mc)) begin
            res = '{ST_ADJACENT, mr[4:0], mc[4:0], 5'd0, 5'd0};
            return;
        end
        wave_dist[mr * GRID + mc] = 0;
        lvl = 0;
        forever begin
            grew = 0;
            for (int i = 0; i < CELLS; i++) begin
                if (wave_dist[i] != lvl) continue;
                if (touches_target(i / GRID, i % GRID)) begin
                    gr = i / GRID;
                    gc = i % GRID;
                    found_goal = 1;
                    break;
                end
                for (int d = 0; d < 4; d++) begin
                    if (!step_to(i / GRID, i % GRID, d, nr, nc)) continue;
                    j = nr * GRID + nc;
                    if (shadow_map[j] == CODE_FREE && wave_dist[j] == UNLABELED) begin
                        wave_dist[j] = lvl + 1;
                        grew = 1;
                    end
                end
            end
            if (found_goal || !grew) break;
            lvl++;
        end
        if (!found_goal) begin
            res = '{ST_NO_PATH, mr[4:0], mc[4:0], 5'd0, 5'd0};
            return;
        end
        for (int s = 0; s < CELLS; s++) begin
            here = wave_dist[gr * GRID + gc];
            near_mover = 0;
            for (int d = 0; d < 4; d++)
                if (step_to(gr, gc, d, nr, nc) && wave_dist[nr * GRID + nc] == 0)
                    near_mover = 1;
            if (near_mover || here == 0 || here == UNLABELED) break;
            moved = 0;
            for (int d = 0; d < 4 && !moved; d++)
                if (step_to(gr, gc, d, nr, nc) && wave_dist[nr * GRID + nc] == here - 1) begin
                    gr = nr;
                    gc = nc;
                    moved = 1;
                end
            if (!moved) break;
        end
        shadow_map[gr * GRID + gc] = CODE_MOVER;
        shadow_map[mr * GRID + mc] = CODE_FREE;
        res = '{ST_MOVED, mr[4:0], mc[4:0], gr[4:0], gc[4:0]};
    endtask

    task automatic apply_accepted(grid_cmd_t g);
        step_result_t r;
        n_accepted++;
        if (g.func == FUNC_WRITE) begin
            shadow_map[g.row * GRID + g.col] = g.code;
        end else begin
            route_one_step(r);
            n_runs++;
            pending_steps.push_back(g.fixed ? g.want : r);
        end
    endtask

    task automatic send(grid_cmd_t g);
        if (!quiet && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= g.func;
        s_axis_tdata <= {3'b000, g.code, g.col, g.row};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_accepted(g);
    endtask

    function automatic logic [2:0] random_code();
        int v;
        v = $urandom_range(0, 99);
        if (v < 70) return CODE_FREE;
        if (v < 82) return CODE_WALL;
        if (v < 86) return CODE_CHEST;
        if (v < 89) return CODE_OBJECTIVE;
        if (v < 91) return CODE_SIX;
        if (v < 93) return CODE_SEVEN;
        if (v < 97) return CODE_TARGET;
        return CODE_MOVER;
    endfunction

    // receiver: random stalls, one long hold-off, result checking
    always @(posedge i_clk) begin
        step_result_t got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[9:5],
                    m_axis_tdata[14:10], m_axis_tdata[19:15]};
            if (pending_steps.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transaction %h", got);
            end else begin
                want = pending_steps.pop_front();
                if (got.status !== want.status || got.mover_row !== want.mover_row ||
                    got.mover_col !== want.mover_col || got.next_row !== want.next_row ||
                    got.next_col !== want.next_col) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %0d (%0d,%0d) (%0d,%0d) got %0d (%0d,%0d) (%0d,%0d)",
                                 want.status, want.mover_row, want.mover_col, want.next_row,
                                 want.next_col, got.status, got.mover_row, got.mover_col,
                                 got.next_row, got.next_col);
                end
            end
        end
        if (!hold_done && n_runs >= 14) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    initial begin
        int r0, c0, h, w, mr, mc, tr, tc, item_goal;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_WRITE;
        i_rst_n <= 1'b0;
        n_accepted = 0;
        n_runs = 0;
        n_mismatch = 0;
        quiet = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the whole map must be written before any run
        for (int i = 0; i < CELLS; i++) send(wr(i / GRID, i % GRID, CODE_WALL));

        directed_tbl = '{
            rn_fixed(ST_NO_MOVER, 0, 0),
            wr(0, 0, CODE_MOVER), wr(0, 1, CODE_TARGET),
            rn_fixed(ST_ADJACENT, 0, 0),
            wr(0, 1, CODE_FREE), wr(0, 2, CODE_FREE), wr(0, 3, CODE_TARGET),
            rn(), rn(),
            rn_fixed(ST_ADJACENT, 0, 2),
            wr(0, 3, CODE_WALL),
            rn_fixed(ST_NO_PATH, 0, 2),
            wr(31, 31, CODE_SEVEN), wr(31, 30, CODE_SIX),
            wr(31, 0, CODE_CHEST), wr(0, 31, CODE_OBJECTIVE),
            // second mover later in scan order is the one that the run reports
            wr(1, 0, CODE_MOVER), wr(2, 0, CODE_TARGET),
            rn_fixed(ST_ADJACENT, 1, 0),
            wr(1, 0, CODE_WALL), wr(2, 0, CODE_WALL), wr(0, 0, CODE_WALL),
            wr(0, 1, CODE_WALL), wr(0, 2, CODE_WALL),
            rn_fixed(ST_NO_MOVER, 0, 0)
        };
        foreach (directed_tbl[k]) send(directed_tbl[k]);

        // random rooms at random places, fenced by the wall background
        item_goal = n_accepted + 580;
        while (n_accepted < item_goal) begin
            quiet = (n_accepted > item_goal - 420) && (n_accepted < item_goal - 250);
            h = $urandom_range(3, 6);
            w = $urandom_range(3, 6);
            r0 = $urandom_range(0, GRID - h);
            c0 = $urandom_range(0, GRID - w);
            for (int r = r0; r < r0 + h; r++)
                for (int c = c0; c < c0 + w; c++)
                    send(wr(r, c, random_code()));
            mr = $urandom_range(r0, r0 + h - 1);
            mc = $urandom_range(c0, c0 + w - 1);
            do begin
                tr = $urandom_range(r0, r0 + h - 1);
                tc = $urandom_range(c0, c0 + w - 1);
            end while (tr == mr && tc == mc);
            if ($urandom_range(0, 9) != 0) send(wr(mr, mc, CODE_MOVER));
            if ($urandom_range(0, 9) != 0) send(wr(tr, tc, CODE_TARGET));
            repeat ($urandom_range(2, 4)) begin
                send(rn());
                if ($urandom_range(0, 3) == 0)
                    send(wr($urandom_range(r0, r0 + h - 1), $urandom_range(c0, c0 + w - 1),
                            random_code()));
            end
            for (int r = r0; r < r0 + h; r++)
                for (int c = c0; c < c0 + w; c++)
                    send(wr(r, c, CODE_WALL));
        end
        quiet = 0;
        s_axis_tvalid <= 1'b0;

        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
